@@ sv/sct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and character-class functions for the source tokenizer.
// No dependencies; every other file of the block imports this package.
package sct_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int OUT_LEN_W    = 16;
    localparam int KIND_W       = 5;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    // Register map: index is paddr[2]
    localparam logic REG_COMMENT_CHAR = 1'b0;
    localparam logic [7:0] COMMENT_CHAR_RST = 8'd35;

    // Token kinds
    localparam logic [KIND_W-1:0] K_ILLEGAL = 5'd0;
    localparam logic [KIND_W-1:0] K_END     = 5'd1;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd2;
    localparam logic [KIND_W-1:0] K_INT     = 5'd3;
    localparam logic [KIND_W-1:0] K_FLOAT   = 5'd4;
    localparam logic [KIND_W-1:0] K_STRING  = 5'd5;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd6;
    localparam logic [KIND_W-1:0] K_EQUAL   = 5'd7;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd8;
    localparam logic [KIND_W-1:0] K_COLON   = 5'd9;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd10;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd11;
    localparam logic [KIND_W-1:0] K_LBRACE  = 5'd12;
    localparam logic [KIND_W-1:0] K_RBRACE  = 5'd13;
    localparam logic [KIND_W-1:0] K_LBRACK  = 5'd14;
    localparam logic [KIND_W-1:0] K_RBRACK  = 5'd15;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd16;
    localparam logic [KIND_W-1:0] K_DOT     = 5'd17;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd18;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd19;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd20;
    localparam logic [KIND_W-1:0] K_BANG    = 5'd21;
    localparam logic [KIND_W-1:0] K_NOTEQ   = 5'd22;
    localparam logic [KIND_W-1:0] K_SLASH   = 5'd23;
    localparam logic [KIND_W-1:0] K_LESS    = 5'd24;
    localparam logic [KIND_W-1:0] K_GREATER = 5'd25;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_US    = 8'h5F;

    // Up to three result items caused by one byte, in this order:
    // close of the running token, one literal byte, close of a new token.
    typedef struct packed {
        logic                 has_c0;
        logic [KIND_W-1:0]    kind0;
        logic [OUT_LEN_W-1:0] len0;
        logic                 has_b;
        logic [7:0]           chr;
        logic                 has_c1;
        logic [KIND_W-1:0]    kind1;
        logic [OUT_LEN_W-1:0] len1;
    } t_bundle;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    // Single-character tokens; anything else is illegal
    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            8'h3B:   k = K_SEMI;
            8'h3A:   k = K_COLON;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h2C:   k = K_COMMA;
            8'h2E:   k = K_DOT;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h3C:   k = K_LESS;
            8'h3E:   k = K_GREATER;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] len_inc(input logic [LENGTH_WIDTH-1:0] l);
        return (l == {LENGTH_WIDTH{1'b1}}) ? l : l + LENGTH_WIDTH'(1);
    endfunction

    // Clamp the internal length to the reported field
    function automatic logic [OUT_LEN_W-1:0] len_out(input logic [LENGTH_WIDTH-1:0] l);
        logic [31:0] t;
        t = 32'(l);
        return (t > 32'(16'hFFFF)) ? {OUT_LEN_W{1'b1}} : t[OUT_LEN_W-1:0];
    endfunction

endpackage

@@ sv/sct_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts source bytes, runs the lexer mode machine and builds result bundles.
// Depends on sct_pkg.
module sct_front import sct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_char,
    input  logic [7:0]  i_comment_char,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_bundle     o_bundle
);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_IDENT   = 3'd1;
    localparam logic [2:0] M_NUMBER  = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_COMMENT = 3'd4;
    localparam logic [2:0] M_EQ      = 3'd5;
    localparam logic [2:0] M_BANG    = 3'd6;

    logic [2:0]              r_mode, n_mode;
    logic                    r_dot, n_dot;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    t_bundle                 b;
    logic                    start;
    logic                    accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        b      = '0;
        b.chr  = i_char;
        n_mode = r_mode;
        n_dot  = r_dot;
        n_len  = r_len;
        start  = 1'b0;

        unique case (r_mode) inside
            M_IDENT: begin
                if (is_alpha(i_char) || is_num(i_char)) begin
                    b.has_b = 1'b1;
                    n_len   = len_inc(r_len);
                end else begin
                    b.has_c0 = 1'b1;
                    b.kind0  = K_IDENT;
                    b.len0   = len_out(r_len);
                    start    = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_num(i_char) || i_char == CH_DOT) begin
                    b.has_b = 1'b1;
                    n_len   = len_inc(r_len);
                    if (i_char == CH_DOT) begin
                        n_dot = 1'b1;
                    end
                end else begin
                    b.has_c0 = 1'b1;
                    b.kind0  = r_dot ? K_FLOAT : K_INT;
                    b.len0   = len_out(r_len);
                    start    = 1'b1;
                end
            end
            M_STRING: begin
                if (i_char == CH_QUOTE) begin
                    b.has_c0 = 1'b1;
                    b.kind0  = K_STRING;
                    b.len0   = len_out(r_len);
                    n_mode   = M_IDLE;
                    n_len    = '0;
                    n_dot    = 1'b0;
                end else if (i_char == CH_NUL) begin
                    b.has_c0 = 1'b1;
                    b.kind0  = K_STRING;
                    b.len0   = len_out(r_len);
                    start    = 1'b1;
                end else begin
                    b.has_b = 1'b1;
                    n_len   = len_inc(r_len);
                end
            end
            M_COMMENT: begin
                if (i_char == CH_NL) begin
                    n_mode = M_IDLE;
                end else if (i_char == CH_NUL) begin
                    start = 1'b1;
                end
            end
            M_EQ, M_BANG: begin
                if (i_char == CH_EQ) begin
                    b.has_b  = 1'b1;
                    b.has_c1 = 1'b1;
                    b.kind1  = (r_mode == M_EQ) ? K_EQUAL : K_NOTEQ;
                    b.len1   = len_out(len_inc(r_len));
                    n_mode   = M_IDLE;
                    n_len    = '0;
                    n_dot    = 1'b0;
                end else begin
                    b.has_c0 = 1'b1;
                    b.kind0  = (r_mode == M_EQ) ? K_ASSIGN : K_BANG;
                    b.len0   = len_out(r_len);
                    start    = 1'b1;
                end
            end
            default: begin
                start = 1'b1;
            end
        endcase

        // Fresh token start from this byte
        if (start) begin
            n_mode = M_IDLE;
            n_len  = '0;
            n_dot  = 1'b0;
            if (i_char == CH_NUL) begin
                b.has_c1 = 1'b1;
                b.kind1  = K_END;
                b.len1   = '0;
            end else if (i_char == i_comment_char) begin
                n_mode = M_COMMENT;
            end else if (is_space(i_char)) begin
                n_mode = M_IDLE;
            end else if (i_char == CH_QUOTE) begin
                n_mode = M_STRING;
            end else if (is_alpha(i_char)) begin
                b.has_b = 1'b1;
                n_len   = LENGTH_WIDTH'(1);
                n_mode  = M_IDENT;
            end else if (is_num(i_char)) begin
                b.has_b = 1'b1;
                n_len   = LENGTH_WIDTH'(1);
                n_mode  = M_NUMBER;
            end else if (i_char == CH_EQ) begin
                b.has_b = 1'b1;
                n_len   = LENGTH_WIDTH'(1);
                n_mode  = M_EQ;
            end else if (i_char == CH_BANG) begin
                b.has_b = 1'b1;
                n_len   = LENGTH_WIDTH'(1);
                n_mode  = M_BANG;
            end else begin
                b.has_b  = 1'b1;
                b.has_c1 = 1'b1;
                b.kind1  = punct_kind(i_char);
                b.len1   = len_out(LENGTH_WIDTH'(1));
            end
        end
    end

    assign o_bundle = b;
    assign o_push   = accept && (b.has_c0 || b.has_b || b.has_c1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_dot  <= 1'b0;
            r_len  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_len  <= n_len;
        end
    end

endmodule

@@ sv/sct_queue.sv @@
`timescale 1ns / 1ps
// Short bundle queue between the front end and the result sequencer.
// Depends on sct_pkg.
module sct_queue import sct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_bundle o_data
);

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

@@ sv/sct_back.sv @@
`timescale 1ns / 1ps
// Back end: unpacks one bundle into result transactions, one per cycle while i_ready is high, from registers.
// Depends on sct_pkg.
module sct_back import sct_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_bundle              i_q_data,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [KIND_W-1:0]    o_token_kind,
    output logic [7:0]           o_literal_byte,
    output logic                 o_byte_valid,
    output logic                 o_token_end,
    output logic [OUT_LEN_W-1:0] o_literal_length,
    output logic                 o_last
);

    t_bundle    r_cur;
    logic [2:0] r_pend;
    logic       fire;
    logic       done;

    assign o_valid = (r_pend != 3'b000);
    assign o_last  = ((r_pend & (r_pend - 3'd1)) == 3'b000);
    assign fire    = o_valid && i_ready;
    assign done    = !o_valid || (fire && o_last);
    assign o_q_pop = done && i_q_valid;

    // Lowest pending slot goes out first
    always_comb begin
        o_token_kind     = '0;
        o_literal_byte   = '0;
        o_byte_valid     = 1'b0;
        o_token_end      = 1'b0;
        o_literal_length = '0;
        if (r_pend[0]) begin
            o_token_kind     = r_cur.kind0;
            o_token_end      = 1'b1;
            o_literal_length = r_cur.len0;
        end else if (r_pend[1]) begin
            o_literal_byte = r_cur.chr;
            o_byte_valid   = 1'b1;
        end else if (r_pend[2]) begin
            o_token_kind     = r_cur.kind1;
            o_token_end      = 1'b1;
            o_literal_length = r_cur.len1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else if (o_q_pop) begin
            r_pend <= {i_q_data.has_c1, i_q_data.has_b, i_q_data.has_c0};
        end else if (fire) begin
            r_pend <= r_pend & (r_pend - 3'd1);
        end
    end

endmodule

@@ sv/source_code_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// Top level of the streaming source tokenizer: APB register, front end, queue, back end.
// Depends on sct_pkg, sct_front, sct_queue and sct_back.

// The tokenizer takes source text one byte per transaction on the char channel
// (byte 0 ends the text) and returns token results on the token channel: one
// transaction per literal byte, then a closing transaction with the token kind
// and its saturated length; o_last marks the final result caused by an input
// byte. Whitespace outside strings and comment bytes cause no literal result.
// The front end classifies a byte in the cycle it is accepted and queues a
// bundle of up to three results; the back end drives them out of registers,
// one per cycle while i_tok_ready is high. A byte is accepted in every cycle
// the two-entry queue has room; once the queue is full, the input waits on the
// single result port, which sends up to three results per byte (one for most
// bytes inside a token). The first result of a byte passes through the queue
// and the back end's r_cur register before it is driven. The comment character
// register sits at byte address 0 (reset 0x23); it must be written only while
// the block is idle, which the block itself does not enforce.
module source_code_tokenizer_unit import sct_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Source bytes
    input  logic                 i_char_valid,
    output logic                 o_char_ready,
    input  logic [7:0]           i_char_in,
    // Token results
    output logic                 o_tok_valid,
    input  logic                 i_tok_ready,
    output logic [KIND_W-1:0]    o_token_kind,
    output logic [7:0]           o_literal_byte,
    output logic                 o_byte_valid,
    output logic                 o_token_end,
    output logic [OUT_LEN_W-1:0] o_literal_length,
    output logic                 o_last
);

    logic [7:0] r_comment_char;
    logic       cfg_wr;
    logic       q_full;
    logic       q_push;
    logic       q_valid;
    logic       q_pop;
    t_bundle    f_bundle;
    t_bundle    q_bundle;

    // Register file: one byte-wide register, zero-wait
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COMMENT_CHAR);
    assign prdata = (paddr[2] == REG_COMMENT_CHAR) ? {24'd0, r_comment_char} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comment_char <= COMMENT_CHAR_RST;
        end else if (cfg_wr) begin
            r_comment_char <= pwdata[7:0];
        end
    end

    // Classify bytes and track the lexer mode
    sct_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_char_valid),
        .i_char         (i_char_in),
        .i_comment_char (r_comment_char),
        .i_full         (q_full),
        .o_ready        (o_char_ready),
        .o_push         (q_push),
        .o_bundle       (f_bundle)
    );

    // Decouple classification from result delivery
    sct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_bundle),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_bundle)
    );

    // Serialize bundles onto the result channel
    sct_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (q_bundle),
        .o_q_pop          (q_pop),
        .o_valid          (o_tok_valid),
        .i_ready          (i_tok_ready),
        .o_token_kind     (o_token_kind),
        .o_literal_byte   (o_literal_byte),
        .o_byte_valid     (o_byte_valid),
        .o_token_end      (o_token_end),
        .o_literal_length (o_literal_length),
        .o_last           (o_last)
    );

endmodule

@@ sv/sct_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on sct_pkg and source_code_tokenizer_unit.
module sct_checker import sct_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_tok_valid,
    input logic                 i_tok_ready,
    input logic [KIND_W-1:0]    o_token_kind,
    input logic [7:0]           o_literal_byte,
    input logic                 o_byte_valid,
    input logic                 o_token_end,
    input logic [OUT_LEN_W-1:0] o_literal_length,
    input logic                 o_last
);

    // No result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_tok_valid)
        else $error("result valid right after reset");

    // Every result is either a literal byte or a closing item
    a_one_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid |-> (o_byte_valid ^ o_token_end))
        else $error("result is neither or both byte and close");

    // Byte items carry no kind and no length
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_valid && o_byte_valid) |-> (o_token_kind == K_ILLEGAL && o_literal_length == '0))
        else $error("byte item carries kind or length");

    // END closes the results of its byte and has no literal
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_valid && o_token_end && o_token_kind == K_END)
            |-> (o_last && o_literal_length == '0))
        else $error("END item not last or nonzero length");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_valid && !i_tok_ready) |=> (o_tok_valid && $stable(o_literal_byte)
            && $stable(o_token_kind) && $stable(o_literal_length) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind source_code_tokenizer_unit sct_checker u_sct_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_tok_valid      (o_tok_valid),
    .i_tok_ready      (i_tok_ready),
    .o_token_kind     (o_token_kind),
    .o_literal_byte   (o_literal_byte),
    .o_byte_valid     (o_byte_valid),
    .o_token_end      (o_token_end),
    .o_literal_length (o_literal_length),
    .o_last           (o_last)
);
